### rtl/obps_pkg.sv
// shared types and constants of the output blink pattern sequencer
// no dependencies; used by the top level and the slot table
package obps_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = 2;
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_W     = 3;
    localparam int SLOT_CNT_W = 4;
    localparam int STEP_W     = 4;
    localparam int PTR_W      = 5;
    localparam int TIME_W     = 16;
    localparam int REP_W      = 8;
    localparam int PRIO_W     = 8;
    localparam int ID_W       = 4;
    localparam int CMD_W      = 4;

    localparam int MEM_AW     = CH_W + SLOT_W + STEP_W;
    localparam int MEM_DEPTH  = 1 << MEM_AW;
    localparam int STEP_BITS  = 2 * TIME_W + REP_W;
    localparam int TABLE_N    = NUM_CH * NUM_SLOTS;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [REP_W-1:0]  REP_MAX  = '1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TEST   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ADD    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ON     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_OFF    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 4'd9;

    typedef struct packed {
        logic run;
        logic test;
        logic phase;
        logic done;
        logic level;
    } t_flags;

    typedef struct packed {
        logic [REP_W-1:0]  rep;
        logic [TIME_W-1:0] off;
        logic [TIME_W-1:0] on;
    } t_step;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [ID_W-1:0]   find_id;
        logic [ID_W-1:0]   test_id;
        logic [SLOT_W-1:0] rd_cur;
        logic              add_en;
        logic              add_one;
        logic [PRIO_W-1:0] add_prio;
    } t_slot_req;

    typedef struct packed {
        logic [SLOT_CNT_W-1:0] count;
        logic                  find_hit;
        logic [SLOT_W-1:0]     find_idx;
        logic [PRIO_W-1:0]     find_prio;
        logic                  test_hit;
        logic [SLOT_W-1:0]     test_idx;
        logic [ID_W-1:0]       cur_id;
        logic                  cur_one;
        logic [PRIO_W-1:0]     cur_prio;
    } t_slot_rsp;

endpackage

### rtl/output_blink_pattern_sequencer.sv
// top level of the output blink pattern sequencer: command sequencer and channel state
// depends on obps_pkg, obps_ram (step store) and obps_slot_table
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata item fields
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_data test pattern id
//
// one item at a time: transfer, decode, then one or more step memory reads, each
// an address state then a data state; the last read gives the busy status
// reset clears channel valids, flags, pointers, timers, repeat and pattern counts
// but not the slot indices; step memory needs no clearing
// a result waits in the output register; the next item is taken meanwhile and stalls
// only when its own result is ready while the previous one is still held
module output_blink_pattern_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel, elapsed_ms, pattern_id, mode_flag, pattern_priority, step_number,
    // on_time_ms, off_time_ms, repeat_count, zero fill
    input  logic [79:0] s_axis_tdata,
    // command
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted, output_levels, current_pattern, channel_busy, one_shot_done, zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_RD   = 4'b0100,
        ST_DATA = 4'b1000
    } t_state;

    typedef enum logic [6:0] {
        K_TICK    = 7'b0000001,
        K_START   = 7'b0000010,
        K_SETST   = 7'b0000100,
        K_ADV_ON  = 7'b0001000,
        K_ADV_OFF = 7'b0010000,
        K_SETOUT  = 7'b0100000,
        K_FINAL   = 7'b1000000
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind, v_kind;

    logic [obps_pkg::CMD_W-1:0]  r_cmd;
    logic [obps_pkg::CH_W-1:0]   r_ch;
    logic [obps_pkg::TIME_W-1:0] r_dt;
    logic [obps_pkg::ID_W-1:0]   r_pid;
    logic                        r_mode;
    logic [obps_pkg::PRIO_W-1:0] r_prio;
    logic [obps_pkg::STEP_W-1:0] r_sn;
    obps_pkg::t_step             r_step;
    logic [obps_pkg::ID_W-1:0]   r_test_id;

    logic                        r_cur_vld [obps_pkg::NUM_CH];
    logic [obps_pkg::SLOT_W-1:0] r_cur     [obps_pkg::NUM_CH];
    logic                        r_sav_vld [obps_pkg::NUM_CH];
    logic [obps_pkg::SLOT_W-1:0] r_sav     [obps_pkg::NUM_CH];
    logic [obps_pkg::STEP_W-1:0] r_ptr     [obps_pkg::NUM_CH];
    logic [obps_pkg::TIME_W-1:0] r_el      [obps_pkg::NUM_CH];
    logic [obps_pkg::REP_W-1:0]  r_rc      [obps_pkg::NUM_CH];
    obps_pkg::t_flags            r_flags   [obps_pkg::NUM_CH];

    logic                        r_w_cur_vld, n_w_cur_vld;
    logic [obps_pkg::SLOT_W-1:0] r_w_cur, n_w_cur;
    logic                        r_w_sav_vld, n_w_sav_vld;
    logic [obps_pkg::SLOT_W-1:0] r_w_sav, n_w_sav;
    logic [obps_pkg::PTR_W-1:0]  r_w_ptr, n_w_ptr;
    logic [obps_pkg::TIME_W-1:0] r_w_el, n_w_el;
    logic [obps_pkg::REP_W-1:0]  r_w_rc, n_w_rc;
    obps_pkg::t_flags            r_w_flags, n_w_flags;
    logic                        r_acc, n_acc;

    logic [obps_pkg::MEM_AW-1:0] r_rd_addr, n_rd_addr;
    logic                        r_rd_sent, n_rd_sent;
    logic                        r_m_valid;
    logic [15:0]                 r_m_data, n_m_data;

    logic [obps_pkg::CH_W-1:0]     in_ch;
    logic                          accept;
    logic                          v_rd;
    logic                          wb_en;
    logic                          m_load;
    logic                          ram_we;
    logic [obps_pkg::STEP_BITS-1:0] ram_rdata;
    obps_pkg::t_step               d;
    logic                          d_end;
    logic                          one;
    logic                          busy;
    logic                          sub;
    logic                          nxt;
    logic                          done_n;
    logic [obps_pkg::TIME_W:0]     sum;
    logic [obps_pkg::TIME_W-1:0]   sat;
    logic [obps_pkg::REP_W-1:0]    rc1;
    logic [obps_pkg::NUM_CH-1:0]   levels;
    obps_pkg::t_slot_req           slot_req;
    obps_pkg::t_slot_rsp           slot_rsp;

    assign in_ch         = s_axis_tdata[1:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign slot_req.ch       = r_ch;
    assign slot_req.find_id  = r_pid;
    assign slot_req.test_id  = r_test_id;
    assign slot_req.rd_cur   = r_w_cur;
    assign slot_req.add_one  = r_mode;
    assign slot_req.add_prio = r_prio;

    obps_slot_table u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

    obps_ram #(
        .WIDTH (obps_pkg::STEP_BITS),
        .DEPTH (obps_pkg::MEM_DEPTH)
    ) u_steps (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_ch, slot_rsp.find_idx, r_sn}),
        .i_wdata (r_step),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_w_cur_vld = r_w_cur_vld;
        n_w_cur     = r_w_cur;
        n_w_sav_vld = r_w_sav_vld;
        n_w_sav     = r_w_sav;
        n_w_ptr     = r_w_ptr;
        n_w_el      = r_w_el;
        n_w_rc      = r_w_rc;
        n_w_flags   = r_w_flags;
        n_acc       = r_acc;
        v_rd        = 1'b0;
        v_kind      = K_FINAL;
        wb_en       = 1'b0;
        m_load      = 1'b0;
        ram_we      = 1'b0;
        slot_req.add_en = 1'b0;

        d      = r_rd_sent ? {{obps_pkg::REP_W{1'b0}}, obps_pkg::TIME_MAX, obps_pkg::TIME_MAX}
                           : obps_pkg::t_step'(ram_rdata);
        d_end  = (d.on == obps_pkg::TIME_MAX) && (d.off == obps_pkg::TIME_MAX);
        one    = r_w_cur_vld & slot_rsp.cur_one;
        sum    = {1'b0, r_w_el} + {1'b0, r_dt};
        sat    = sum[obps_pkg::TIME_W] ? obps_pkg::TIME_MAX : sum[obps_pkg::TIME_W-1:0];
        sub    = r_w_flags.phase & (sat >= d.on) & (d.on != obps_pkg::TIME_MAX);
        nxt    = !r_w_flags.phase & (sat >= d.off) & (d.off != obps_pkg::TIME_MAX);
        rc1    = (r_w_rc < obps_pkg::REP_MAX) ? r_w_rc + obps_pkg::REP_W'(1) : r_w_rc;
        done_n = r_w_flags.done | (d_end & one);
        busy   = r_w_cur_vld & r_w_flags.run & !r_w_flags.done & (d.off != obps_pkg::TIME_MAX);

        for (int c = 0; c < obps_pkg::NUM_CH; c++) begin
            levels[c] = (obps_pkg::CH_W'(c) == r_ch) ? r_w_flags.level : r_flags[c].level;
        end
        n_m_data = {5'b0, r_w_flags.done, busy,
                    (r_w_cur_vld ? slot_rsp.cur_id : {obps_pkg::ID_W{1'b0}}),
                    levels, r_acc};

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state     = ST_EXEC;
                    n_acc       = 1'b0;
                    n_w_cur_vld = r_cur_vld[in_ch];
                    n_w_cur     = r_cur[in_ch];
                    n_w_sav_vld = r_sav_vld[in_ch];
                    n_w_sav     = r_sav[in_ch];
                    n_w_ptr     = {1'b0, r_ptr[in_ch]};
                    n_w_el      = r_el[in_ch];
                    n_w_rc      = r_rc[in_ch];
                    n_w_flags   = r_flags[in_ch];
                end
            end
            ST_EXEC: begin
                v_rd = 1'b1;
                case (r_cmd)
                    obps_pkg::CMD_TICK: begin
                        if (!r_w_flags.run || r_w_flags.done) begin
                            n_acc = 1'b1;
                        end else if (r_w_cur_vld) begin
                            n_acc  = 1'b1;
                            v_kind = K_TICK;
                        end
                    end
                    obps_pkg::CMD_START: begin
                        if (!r_w_flags.run && r_w_cur_vld) begin
                            v_kind = K_START;
                        end
                    end
                    obps_pkg::CMD_STOP: begin
                        n_acc = 1'b1;
                        if (r_w_flags.run) begin
                            n_w_flags.run   = 1'b0;
                            n_w_flags.phase = 1'b0;
                            n_w_flags.done  = 1'b0;
                            n_w_flags.level = 1'b0;
                            n_w_ptr = '0;
                            n_w_el  = '0;
                            n_w_rc  = '0;
                        end
                    end
                    obps_pkg::CMD_SET: begin
                        if (slot_rsp.find_hit && r_w_cur_vld
                                && !(slot_rsp.cur_prio > slot_rsp.find_prio)
                                && !(slot_rsp.cur_id == r_pid && !r_w_flags.done)) begin
                            n_acc = 1'b1;
                            if (r_w_flags.test) begin
                                n_w_sav_vld = 1'b1;
                                n_w_sav     = slot_rsp.find_idx;
                            end else begin
                                n_w_flags.run   = 1'b0;
                                n_w_flags.phase = 1'b0;
                                n_w_flags.done  = 1'b0;
                                n_w_flags.level = 1'b0;
                                n_w_ptr     = '0;
                                n_w_el      = '0;
                                n_w_rc      = '0;
                                n_w_cur_vld = 1'b1;
                                n_w_cur     = slot_rsp.find_idx;
                                if (r_w_flags.run) begin
                                    v_kind = K_SETST;
                                end
                            end
                        end
                    end
                    obps_pkg::CMD_TEST: begin
                        n_acc = 1'b1;
                        if (r_w_flags.test != r_mode) begin
                            n_w_flags.test  = r_mode;
                            n_w_flags.phase = 1'b0;
                            n_w_flags.done  = 1'b0;
                            n_w_flags.level = 1'b0;
                            n_w_ptr = '0;
                            n_w_el  = '0;
                            n_w_rc  = '0;
                            if (r_mode) begin
                                n_w_sav_vld = r_w_cur_vld;
                                n_w_sav     = r_w_cur;
                                n_w_cur_vld = slot_rsp.test_hit;
                                n_w_cur     = slot_rsp.test_idx;
                            end else begin
                                n_w_cur_vld = r_w_sav_vld;
                                n_w_cur     = r_w_sav;
                            end
                        end
                    end
                    obps_pkg::CMD_ADD: begin
                        if (!slot_rsp.find_hit
                                && slot_rsp.count < obps_pkg::SLOT_CNT_W'(obps_pkg::NUM_SLOTS)) begin
                            slot_req.add_en = 1'b1;
                            n_acc = 1'b1;
                            if (!r_w_cur_vld) begin
                                n_w_cur_vld = 1'b1;
                                n_w_cur     = slot_rsp.count[obps_pkg::SLOT_W-1:0];
                                n_w_sav_vld = 1'b1;
                                n_w_sav     = slot_rsp.count[obps_pkg::SLOT_W-1:0];
                            end
                        end
                    end
                    obps_pkg::CMD_LOAD: begin
                        if (slot_rsp.find_hit) begin
                            ram_we = 1'b1;
                            n_acc  = 1'b1;
                        end
                    end
                    obps_pkg::CMD_ON: begin
                        if (!r_w_flags.run) begin
                            n_w_flags.level = 1'b1;
                            n_acc = 1'b1;
                        end
                    end
                    obps_pkg::CMD_OFF: begin
                        if (!r_w_flags.run) begin
                            n_w_flags.level = 1'b0;
                            n_acc = 1'b1;
                        end
                    end
                    obps_pkg::CMD_TOGGLE: begin
                        if (!r_w_flags.run) begin
                            n_w_flags.level = !r_w_flags.level;
                            n_acc = 1'b1;
                        end
                    end
                    default: begin
                        n_acc = 1'b0;
                    end
                endcase
            end
            ST_RD: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                case (r_kind)
                    K_TICK: begin
                        v_rd   = 1'b1;
                        n_w_el = (sub || nxt) ? '0 : sat;
                        if (sub) begin
                            if (d.off != '0) begin
                                n_w_flags.phase = 1'b0;
                                n_w_flags.level = 1'b0;
                            end else begin
                                n_w_ptr = r_w_ptr + obps_pkg::PTR_W'(1);
                                v_kind  = K_ADV_ON;
                            end
                        end else if (nxt) begin
                            if (rc1 >= d.rep) begin
                                n_w_ptr = r_w_ptr + obps_pkg::PTR_W'(1);
                                n_w_rc  = '0;
                            end else begin
                                n_w_rc = rc1;
                            end
                            v_kind = K_ADV_OFF;
                        end
                    end
                    K_START: begin
                        v_rd = 1'b1;
                        if (!d_end) begin
                            n_acc           = 1'b1;
                            n_w_flags.run   = 1'b1;
                            n_w_flags.phase = 1'b0;
                            n_w_flags.done  = 1'b0;
                            n_w_flags.level = 1'b0;
                            n_w_ptr = '0;
                            n_w_el  = '0;
                            n_w_rc  = '0;
                            v_kind  = K_ADV_OFF;
                        end
                    end
                    K_SETST: begin
                        v_rd = 1'b1;
                        if (!d_end) begin
                            n_w_flags.run   = 1'b1;
                            n_w_flags.phase = (d.on != '0);
                            n_w_flags.level = (d.on != '0);
                        end
                    end
                    K_ADV_ON: begin
                        v_rd = 1'b1;
                        if (d_end) begin
                            n_w_ptr = '0;
                        end
                        if (one) begin
                            n_w_flags.done = 1'b1;
                        end else if (d_end) begin
                            v_kind = K_SETOUT;
                        end else begin
                            n_w_flags.phase = (d.on != '0);
                            n_w_flags.level = (d.on != '0);
                        end
                    end
                    K_ADV_OFF: begin
                        v_rd = 1'b1;
                        n_w_flags.done = done_n;
                        if (d_end) begin
                            n_w_ptr = '0;
                        end
                        if (r_w_flags.run && !done_n) begin
                            if (d_end) begin
                                v_kind = K_SETOUT;
                            end else begin
                                n_w_flags.phase = (d.on != '0);
                                n_w_flags.level = (d.on != '0);
                            end
                        end
                    end
                    K_SETOUT: begin
                        v_rd = 1'b1;
                        n_w_flags.phase = (d.on != '0);
                        n_w_flags.level = (d.on != '0);
                    end
                    K_FINAL: begin
                        if (!r_m_valid || m_axis_tready) begin
                            m_load  = 1'b1;
                            wb_en   = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (v_rd) begin
            n_state = ST_RD;
            n_kind  = v_kind;
        end
        n_rd_addr = {r_ch, n_w_cur, n_w_ptr[obps_pkg::STEP_W-1:0]};
        n_rd_sent = n_w_ptr[obps_pkg::PTR_W-1] | !n_w_cur_vld;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= s_axis_tuser;
            r_ch       <= s_axis_tdata[1:0];
            r_dt       <= s_axis_tdata[17:2];
            r_pid      <= s_axis_tdata[21:18];
            r_mode     <= s_axis_tdata[22];
            r_prio     <= s_axis_tdata[30:23];
            r_sn       <= s_axis_tdata[34:31];
            r_step.on  <= s_axis_tdata[50:35];
            r_step.off <= s_axis_tdata[66:51];
            r_step.rep <= s_axis_tdata[74:67];
        end
        if (v_rd) begin
            r_rd_addr <= n_rd_addr;
            r_rd_sent <= n_rd_sent;
        end
        if (m_load) begin
            r_m_data <= n_m_data;
        end
        r_w_cur     <= n_w_cur;
        r_w_sav     <= n_w_sav;
        r_w_ptr     <= n_w_ptr;
        r_w_el      <= n_w_el;
        r_w_rc      <= n_w_rc;
        r_w_flags   <= n_w_flags;
        r_w_cur_vld <= n_w_cur_vld;
        r_w_sav_vld <= n_w_sav_vld;
        r_acc       <= n_acc;
        if (wb_en) begin
            r_cur[r_ch] <= r_w_cur;
            r_sav[r_ch] <= r_w_sav;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kind    <= K_FINAL;
            r_m_valid <= 1'b0;
            r_test_id <= '0;
            for (int c = 0; c < obps_pkg::NUM_CH; c++) begin
                r_cur_vld[c] <= 1'b0;
                r_sav_vld[c] <= 1'b0;
                r_ptr[c]     <= '0;
                r_el[c]      <= '0;
                r_rc[c]      <= '0;
                r_flags[c]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_test_id <= i_cfg_data;
            end
            if (wb_en) begin
                r_cur_vld[r_ch] <= r_w_cur_vld;
                r_sav_vld[r_ch] <= r_w_sav_vld;
                r_ptr[r_ch]     <= r_w_ptr[obps_pkg::STEP_W-1:0];
                r_el[r_ch]      <= r_w_el;
                r_rc[r_ch]      <= r_w_rc;
                r_flags[r_ch]   <= r_w_flags;
            end
        end
    end

endmodule

### rtl/obps_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module obps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/obps_slot_table.sv
// pattern slot table: ids, one-shot flags, priorities and fill counts per channel
// depends on obps_pkg
module obps_slot_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  obps_pkg::t_slot_req i_req,
    output obps_pkg::t_slot_rsp o_rsp
);

    logic [obps_pkg::ID_W-1:0]       r_ids  [obps_pkg::TABLE_N];
    logic                            r_one  [obps_pkg::TABLE_N];
    logic [obps_pkg::PRIO_W-1:0]     r_prio [obps_pkg::TABLE_N];
    logic [obps_pkg::SLOT_CNT_W-1:0] r_count [obps_pkg::NUM_CH];

    logic [obps_pkg::SLOT_CNT_W-1:0] cnt;
    logic [obps_pkg::CH_W+obps_pkg::SLOT_W-1:0] base;
    logic [obps_pkg::CH_W+obps_pkg::SLOT_W-1:0] cur_a;
    logic [obps_pkg::CH_W+obps_pkg::SLOT_W-1:0] add_a;

    always_comb begin
        cnt            = r_count[i_req.ch];
        o_rsp.count    = cnt;
        o_rsp.find_hit = 1'b0;
        o_rsp.find_idx = '0;
        o_rsp.test_hit = 1'b0;
        o_rsp.test_idx = '0;
        base           = '0;
        // descending so the lowest matching slot wins
        for (int i = obps_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            base = {i_req.ch, obps_pkg::SLOT_W'(i)};
            if (obps_pkg::SLOT_CNT_W'(i) < cnt && r_ids[base] == i_req.find_id) begin
                o_rsp.find_hit = 1'b1;
                o_rsp.find_idx = obps_pkg::SLOT_W'(i);
            end
            if (obps_pkg::SLOT_CNT_W'(i) < cnt && r_ids[base] == i_req.test_id) begin
                o_rsp.test_hit = 1'b1;
                o_rsp.test_idx = obps_pkg::SLOT_W'(i);
            end
        end
        o_rsp.find_prio = r_prio[{i_req.ch, o_rsp.find_idx}];
        cur_a           = {i_req.ch, i_req.rd_cur};
        o_rsp.cur_id    = r_ids[cur_a];
        o_rsp.cur_one   = r_one[cur_a];
        o_rsp.cur_prio  = r_prio[cur_a];
        add_a           = {i_req.ch, cnt[obps_pkg::SLOT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_req.add_en) begin
            r_ids[add_a]  <= i_req.find_id;
            r_one[add_a]  <= i_req.add_one;
            r_prio[add_a] <= i_req.add_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < obps_pkg::NUM_CH; c++) begin
                r_count[c] <= '0;
            end
        end else if (i_req.add_en) begin
            r_count[i_req.ch] <= cnt + obps_pkg::SLOT_CNT_W'(1);
        end
    end

endmodule
